// ===== rtl/rgbov_pkg.sv =====
// Shared types and constants for the RGBA8 over compositor.
package rgbov_pkg;

  localparam int NUM_CHAN  = 3;
  localparam int DIV_STEPS = 8;

  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  // floor(p / 255) == (p * RECIP_255) >> RECIP_SHIFT for every p up to 255 * 255
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;

  // Payload handed from cell to cell along the divider chain
  typedef struct packed {
    logic                          bypass;  // inactive layer: forward dst unchanged
    logic                          zero;    // output alpha is zero: all channels zero
    logic [31:0]                   dst;
    logic [15:0]                   oa;      // output alpha, Q8.8
    logic [7:0]                    alpha;
    logic [NUM_CHAN-1:0]           sat;     // channel quotient would exceed 255
    logic [NUM_CHAN-1:0][15:0]     rem;     // partial remainder, below oa unless saturated
    logic [NUM_CHAN-1:0][7:0]      quo;     // quotient bits developed so far
  } cell_t;

endpackage

// ===== rtl/rgbov_front.sv =====
// Front end: weighted sums, output alpha and division setup in three stages.
module rgbov_front import rgbov_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  input  logic        layer_active,
  output logic        out_valid,
  input  logic        out_ready,
  output cell_t       out_data
);

  // Stage 1 registers
  logic                      s1_valid;
  logic                      s1_bypass;
  logic [31:0]               s1_dst;
  logic [7:0]                s1_sa;
  logic [15:0]               s1_p;
  logic [NUM_CHAN-1:0][15:0] s1_num;

  // Stage 2 registers
  logic                      s2_valid;
  logic                      s2_bypass;
  logic [31:0]               s2_dst;
  logic [15:0]               s2_oa;
  logic [NUM_CHAN-1:0][15:0] s2_num;

  // Stage 3 register
  logic                      s3_valid;
  cell_t                     s3_data;

  logic s1_ready, s2_ready, s3_ready;

  logic [7:0]                sa, inv, da;
  logic [15:0]               p_next;
  logic [NUM_CHAN-1:0][15:0] num_next;
  logic [31:0]               recip_prod;
  logic [7:0]                corr;
  logic [16:0]               oa_sum;
  cell_t                     s3_next;

  // Each stage loads when empty or when its successor takes its content
  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: alpha product and per-channel weighted sums
  always_comb begin
    sa     = src_pixel[31:24];
    inv    = CHAN_MAX - sa;
    da     = dst_pixel[31:24];
    p_next = {8'd0, da} * {8'd0, inv};
    for (int c = 0; c < NUM_CHAN; c++) begin
      num_next[c] = {8'd0, src_pixel[8*c +: 8]} * {8'd0, sa}
                  + {8'd0, dst_pixel[8*c +: 8]} * {8'd0, inv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_bypass <= !layer_active;
      s1_dst    <= dst_pixel;
      s1_sa     <= sa;
      s1_p      <= p_next;
      s1_num    <= num_next;
    end
  end

  // Stage 2: oa = sa*256 + p + floor(p/255), the division by reciprocal
  always_comb begin
    recip_prod = {16'd0, s1_p} * {16'd0, RECIP_255};
    corr       = recip_prod[RECIP_SHIFT +: 8];
    oa_sum     = {1'b0, s1_sa, 8'd0} + {1'b0, s1_p} + {9'd0, corr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_bypass <= s1_bypass;
      s2_dst    <= s1_dst;
      s2_oa     <= oa_sum[15:0];
      s2_num    <= s1_num;
    end
  end

  // Stage 3: flag zero divisor and saturating channels, seed the remainders
  always_comb begin
    s3_next.bypass = s2_bypass;
    s3_next.zero   = (s2_oa == 16'd0);
    s3_next.dst    = s2_dst;
    s3_next.oa     = s2_oa;
    s3_next.alpha  = s2_oa[15:8];
    for (int c = 0; c < NUM_CHAN; c++) begin
      s3_next.sat[c] = (s2_num[c] >= s2_oa);
      s3_next.rem[c] = s2_num[c];
      s3_next.quo[c] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_data <= s3_next;
    end
  end

  assign out_valid = s3_valid;
  assign out_data  = s3_data;

endmodule

// ===== rtl/rgbov_cell.sv =====
// One restoring-division cell: develops one quotient bit on each channel.
module rgbov_cell import rgbov_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cell_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cell_t out_data
);

  logic  valid;
  cell_t data;
  cell_t data_next;
  logic [16:0] dbl;
  logic [16:0] divisor;
  logic        take;

  assign in_ready = !valid || out_ready;

  // Shift remainder left, subtract divisor where it fits, shift in the bit
  always_comb begin
    data_next = in_data;
    divisor   = {1'b0, in_data.oa};
    dbl       = 17'd0;
    take      = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      dbl  = {in_data.rem[c], 1'b0};
      take = (dbl >= divisor);
      if (take) begin
        dbl = dbl - divisor;
      end
      data_next.rem[c] = dbl[15:0];
      data_next.quo[c] = {in_data.quo[c][6:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== rtl/rgba8_over_compositor.sv =====
// Top level of the RGBA8 over compositor: front end, divider chain, output register.
//
// Takes one pixel pair per clock and returns one blended pixel per clock when the sink
// keeps tready high. The path holds three front-end stages (weighted sums, output
// alpha, divider setup), eight divider cells that each produce one quotient bit of all
// three color channels, and the output register. Every stage holds its own valid bit, so
// empty stages fill while a result waits at the output. An inactive layer leaves
// out_pixel equal to dst_pixel; both alphas zero gives an all-zero pixel.
module rgba8_over_compositor import rgbov_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // src_pixel [31:0], dst_pixel [63:32]
  input  logic        s_tuser,   // layer_active
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_pixel [31:0]
);

  logic  [DIV_STEPS:0] cell_valid;
  logic  [DIV_STEPS:0] cell_ready;
  cell_t               cell_data [DIV_STEPS+1];

  logic        out_load;
  logic [31:0] pixel_next;
  cell_t       last;

  rgbov_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .src_pixel    (s_tdata[31:0]),
    .dst_pixel    (s_tdata[63:32]),
    .layer_active (s_tuser),
    .out_valid    (cell_valid[0]),
    .out_ready    (cell_ready[0]),
    .out_data     (cell_data[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rgbov_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_data   (cell_data[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_data  (cell_data[i+1])
    );
  end

  assign last                  = cell_data[DIV_STEPS];
  assign out_load              = !m_tvalid || m_tready;
  assign cell_ready[DIV_STEPS] = out_load;

  // Assemble the result: pass through, zero, saturate or take the quotient
  always_comb begin
    pixel_next = {last.alpha, 24'd0};
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (last.zero) begin
        pixel_next[8*c +: 8] = 8'd0;
      end else if (last.sat[c]) begin
        pixel_next[8*c +: 8] = CHAN_MAX;
      end else begin
        pixel_next[8*c +: 8] = last.quo[c];
      end
    end
    if (last.bypass) begin
      pixel_next = last.dst;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= cell_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && cell_valid[DIV_STEPS]) begin
      m_tdata <= pixel_next;
    end
  end

  // An empty output register means every stage can take a transfer
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

  // Division leaves each unsaturated remainder below the divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cell_valid[DIV_STEPS] && !last.bypass |->
      (last.sat[0] || last.rem[0] < last.oa) &&
      (last.sat[1] || last.rem[1] < last.oa) &&
      (last.sat[2] || last.rem[2] < last.oa))
    else $error("divider remainder not below output alpha");

  // A zero divisor comes only with a zero output alpha
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    cell_valid[DIV_STEPS] && last.zero |-> last.alpha == 8'd0)
    else $error("zero divisor flagged with nonzero alpha");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
